>>> rtl/vapc_pkg.sv
// Shared types, constants and tables for the visual angle pixel converter.
`default_nettype none
package vapc_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;

  localparam int XW       = 56;
  localparam int ZW       = 34;
  localparam int DIV_BITS = 20;
  localparam int REM_W    = 64;

  localparam logic signed [35:0] RAD_PER_DEG_Q40 = 36'sd19190098069;
  localparam logic signed [22:0] DEG_PER_RAD_Q16 = 23'sd3754936;
  localparam logic signed [19:0] PIX_MAX = 20'sd524287;
  localparam logic signed [19:0] PIX_MIN = -20'sd524288;

  typedef enum logic [1:0] {
    REQ_A2P = 2'd0,
    REQ_P2A = 2'd1,
    REQ_L2A = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_DIST = 3'd0,
    REG_WIDTH = 3'd1,
    REG_RES = 3'd2,
    REG_DENS = 3'd3,
    REG_SRC = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] dist_mm;
    logic [11:0] width;
    logic [12:0] res;
    logic [15:0] dens;
    logic        src;
  } cfg_t;

  typedef struct packed {
    req_t                   req;
    logic                   rot;
    logic                   a_neg;
    logic [28:0]            n;
    logic [11:0]            m;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
  } cord_t;

  typedef struct packed {
    req_t               req;
    logic               a_neg;
    logic               y_neg;
    logic               x_pos;
    logic [59:0]        mag;
    logic [42:0]        den;
    logic signed [56:0] angp;
  } post_t;

  typedef struct packed {
    req_t                req;
    logic                a_neg;
    logic                y_neg;
    logic                x_pos;
    logic                presat;
    logic [REM_W-1:0]    rem;
    logic [43:0]         d2;
    logic [DIV_BITS-1:0] q;
    logic signed [15:0]  ang;
  } div_t;

  function automatic logic [31:0] atan_q30(input int k);
    logic [31:0] r;
    case (k)
      0: r = 32'h3243F6A8;  1: r = 32'h1DAC6705;  2: r = 32'h0FADBAFC;
      3: r = 32'h07F56EA6;  4: r = 32'h03FEAB76;  5: r = 32'h01FFD55B;
      6: r = 32'h00FFFAAA;  7: r = 32'h007FFF55;  8: r = 32'h003FFFEA;
      9: r = 32'h001FFFFD;  10: r = 32'h000FFFFF; 11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF; 13: r = 32'h0001FFFF; 14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF; 16: r = 32'h00003FFF; 17: r = 32'h00001FFF;
      18: r = 32'h00000FFF; 19: r = 32'h000007FF; 20: r = 32'h000003FF;
      21: r = 32'h000001FF; 22: r = 32'h000000FF; 23: r = 32'h0000007F;
      24: r = 32'h0000003F; 25: r = 32'h0000001F; 26: r = 32'h0000000F;
      27: r = 32'h00000008; 28: r = 32'h00000004; 29: r = 32'h00000002;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/visual_angle_pixel_converter.sv
// Top level: configuration registers, post-CORDIC scaling and result register.
// Throughput: one item per cycle; the whole pipeline holds while the output is stalled.
// Front end takes two stages, CORDIC one stage per step, then two scaling stages,
// a 20-stage divider and the output register.
// Reset: synchronous; clears valid bits and loads the register defaults.
`default_nettype none
module visual_angle_pixel_converter import vapc_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [15:0] angle_in,
  input  wire logic signed [19:0] pixels_in,
  input  wire logic signed [16:0] length_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [19:0]      pixels_out,
  output logic signed [15:0]      angle_out,
  output logic                    saturated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int ALIM_RAW = 90 * (1 << ANGLE_FRAC_BITS) - 1;
  localparam int ALIM     = ALIM_RAW > 32767 ? 32767 : ALIM_RAW;
  localparam int ASH      = 46 - ANGLE_FRAC_BITS;

  logic [11:0] screen_distance_mm;
  logic [11:0] screen_width_mm;
  logic [12:0] horizontal_resolution;
  logic [15:0] pixel_density_q8;
  logic        density_source;
  cfg_t        cfg;
  logic        adv;
  logic        c_in_v;
  cord_t       c_in;
  logic        c_out_v;
  cord_t       c_out;
  post_t       pa;
  post_t       pa_next;
  logic        pa_v;
  div_t        db;
  div_t        db_next;
  logic        db_v;
  logic        dv_v;
  div_t        dv;
  logic [30:0] y_mag;
  logic [60:0] num;
  logic [56:0] amag;
  logic [56:0] arnd;
  logic signed [31:0] aval;
  logic signed [19:0] pix_next;
  logic signed [15:0] ang_next;
  logic        sat_next;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_distance_mm    <= 12'd600;
      screen_width_mm       <= 12'd530;
      horizontal_resolution <= 13'd1920;
      pixel_density_q8      <= 16'd927;
      density_source        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_DIST:  screen_distance_mm    <= cfg_data[11:0];
        REG_WIDTH: screen_width_mm       <= cfg_data[11:0];
        REG_RES:   horizontal_resolution <= cfg_data[12:0];
        REG_DENS:  pixel_density_q8      <= cfg_data;
        REG_SRC:   density_source        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.dist_mm = (screen_distance_mm == '0) ? 12'd1 : screen_distance_mm;
    cfg.width   = (screen_width_mm == '0) ? 12'd1 : screen_width_mm;
    cfg.res     = (horizontal_resolution == '0) ? 13'd1 : horizontal_resolution;
    cfg.dens    = (pixel_density_q8 == '0) ? 16'd1 : pixel_density_q8;
    cfg.src     = density_source;
  end

  vapc_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_take(in_valid && !in_stall), .cfg(cfg),
    .req_type(req_type), .angle_in(angle_in), .pixels_in(pixels_in),
    .length_in(length_in), .out_v(c_in_v), .out_d(c_in)
  );

  vapc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .adv(adv), .in_v(c_in_v), .in_d(c_in),
    .out_v(c_out_v), .out_d(c_out)
  );

  always_comb begin
    y_mag         = c_out.y[XW-1] ? 31'(-c_out.y) : 31'(c_out.y);
    pa_next.req   = c_out.req;
    pa_next.a_neg = c_out.a_neg;
    pa_next.y_neg = c_out.y[XW-1];
    pa_next.x_pos = !c_out.x[XW-1] && (c_out.x != '0);
    pa_next.mag   = 60'(y_mag) * 60'(c_out.n);
    pa_next.den   = 43'(c_out.m) * 43'(c_out.x[30:0]);
    pa_next.angp  = 57'(c_out.z) * 57'(DEG_PER_RAD_Q16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_v <= 1'b0;
    end else if (adv) begin
      pa_v <= c_out_v;
    end
    if (adv) pa <= pa_next;
  end

  always_comb begin
    num  = {pa.mag, 1'b0} + 61'(pa.den);
    amag = pa.angp[56] ? 57'(-pa.angp) : 57'(pa.angp);
    arnd = (amag + (57'd1 << (ASH - 1))) >> ASH;
    aval = pa.angp[56] ? -32'($signed({1'b0, arnd[30:0]})) : 32'($signed({1'b0, arnd[30:0]}));
    if (arnd > 57'(ALIM)) aval = pa.angp[56] ? -32'(ALIM) : 32'(ALIM);
    db_next.req    = pa.req;
    db_next.a_neg  = pa.a_neg;
    db_next.y_neg  = pa.y_neg;
    db_next.x_pos  = pa.x_pos;
    db_next.d2     = {pa.den, 1'b0};
    db_next.rem    = REM_W'(num);
    db_next.presat = REM_W'(num) >= (REM_W'({pa.den, 1'b0}) << DIV_BITS);
    db_next.q      = '0;
    db_next.ang    = 16'(aval);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      db_v <= 1'b0;
    end else if (adv) begin
      db_v <= pa_v;
    end
    if (adv) db <= db_next;
  end

  vapc_divider u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_v(db_v), .in_d(db),
    .out_v(dv_v), .out_d(dv)
  );

  always_comb begin
    pix_next = '0;
    ang_next = '0;
    sat_next = 1'b0;
    case (dv.req)
      REQ_A2P: begin
        if (!dv.x_pos) begin
          pix_next = dv.a_neg ? PIX_MIN : PIX_MAX;
          sat_next = 1'b1;
        end else if (dv.presat) begin
          pix_next = dv.y_neg ? PIX_MIN : PIX_MAX;
          sat_next = 1'b1;
        end else if (!dv.y_neg) begin
          if (dv.q > 20'd524287) begin
            pix_next = PIX_MAX;
            sat_next = 1'b1;
          end else begin
            pix_next = $signed(dv.q);
          end
        end else begin
          if (dv.q > 20'd524288) begin
            pix_next = PIX_MIN;
            sat_next = 1'b1;
          end else begin
            pix_next = -$signed(dv.q);
          end
        end
      end
      REQ_P2A, REQ_L2A: ang_next = dv.ang;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v;
    end
    if (adv) begin
      pixels_out <= pix_next;
      angle_out  <= ang_next;
      saturated  <= sat_next;
    end
  end

  a_sat_no_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> angle_out == '0)
    else $error("saturated item carries an angle");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> pixels_out == PIX_MAX || pixels_out == PIX_MIN)
    else $error("saturated item not at a pixel limit");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(dv_v) && $stable(db_v))
    else $error("pipeline advanced during stall");

  a_mode_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && angle_out != '0 |-> pixels_out == '0)
    else $error("both pixel and angle results set");

endmodule
`default_nettype wire

>>> rtl/vapc_front.sv
// Input stages: angle scaling, density products and CORDIC start vectors.
`default_nettype none
module vapc_front import vapc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               in_take,
  input  wire cfg_t               cfg,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [15:0] angle_in,
  input  wire logic signed [19:0] pixels_in,
  input  wire logic signed [16:0] length_in,
  output logic                    out_v,
  output cord_t                   out_d
);

  localparam int ALIM = 90 * (1 << ANGLE_FRAC_BITS) - 1;
  localparam int RSH  = 10 + ANGLE_FRAC_BITS;

  typedef struct packed {
    req_t               req;
    logic               a_neg;
    logic               src;
    logic signed [51:0] radp;
    logic [24:0]        nres;
    logic [27:0]        ndens;
    logic signed [32:0] pw;
    logic signed [19:0] p;
    logic signed [16:0] len;
    logic [11:0]        dist_mm;
    logic [11:0]        width;
  } s1_t;

  s1_t              s1;
  s1_t              s1_next;
  logic             s1_v;
  logic signed [15:0] a_cl;
  cord_t            c_next;
  logic [51:0]      rmag;
  logic [51:0]      rnd;
  logic signed [ZW-1:0] zr;
  logic signed [XW-1:0] bv;
  logic signed [XW-1:0] av;

  always_comb begin
    a_cl = angle_in;
    if (int'(angle_in) > ALIM) a_cl = 16'(ALIM);
    if (int'(angle_in) < -ALIM) a_cl = 16'(-ALIM);
    s1_next.req     = req_t'(req_type);
    s1_next.a_neg   = a_cl[15];
    s1_next.src     = cfg.src;
    s1_next.radp    = 52'(a_cl) * 52'(RAD_PER_DEG_Q40);
    s1_next.nres    = 25'(cfg.res) * 25'(cfg.dist_mm);
    s1_next.ndens   = 28'(cfg.dens) * 28'(cfg.dist_mm);
    s1_next.pw      = 33'(pixels_in) * $signed({21'd0, cfg.width});
    s1_next.p       = pixels_in;
    s1_next.len     = length_in;
    s1_next.dist_mm = cfg.dist_mm;
    s1_next.width   = cfg.width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_take;
    end
    if (adv) s1 <= s1_next;
  end

  always_comb begin
    rmag = s1.radp[51] ? 52'(-s1.radp) : 52'(s1.radp);
    rnd  = (rmag + (52'd1 << (RSH - 1))) >> RSH;
    zr   = s1.radp[51] ? -ZW'($signed({1'b0, rnd})) : ZW'($signed({1'b0, rnd}));
    c_next.req   = s1.req;
    c_next.a_neg = s1.a_neg;
    c_next.n     = s1.src ? 29'(s1.ndens) : {s1.nres, 4'd0};
    c_next.m     = s1.src ? 12'd16 : s1.width;
    if (s1.req == REQ_L2A) begin
      av = XW'(s1.len);
      bv = XW'({s1.dist_mm, 4'd0});
    end else if (s1.src) begin
      av = XW'(s1.p) <<< 4;
      bv = XW'(s1.ndens);
    end else begin
      av = XW'(s1.pw);
      bv = XW'({s1.nres, 4'd0});
    end
    if (s1.req == REQ_A2P) begin
      c_next.rot = 1'b1;
      c_next.x   = XW'(1) <<< 29;
      c_next.y   = '0;
      c_next.z   = zr;
    end else begin
      c_next.rot = 1'b0;
      c_next.x   = bv <<< 20;
      c_next.y   = av <<< 20;
      c_next.z   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= s1_v;
    end
    if (adv) out_d <= c_next;
  end

endmodule
`default_nettype wire

>>> rtl/vapc_cordic.sv
// CORDIC pipeline, one micro-rotation per stage, rotation or vectoring per item.
`default_nettype none
module vapc_cordic import vapc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  adv,
  input  wire logic  in_v,
  input  wire cord_t in_d,
  output logic       out_v,
  output cord_t      out_d
);

  cord_t st [CORDIC_STEPS+1];
  logic  sv [CORDIC_STEPS+1];

  assign st[0] = in_d;
  assign sv[0] = in_v;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q30(i));
    cord_t nx;
    logic  sigma;
    always_comb begin
      nx    = st[i];
      sigma = st[i].rot ? !st[i].z[ZW-1] : st[i].y[XW-1];
      if (sigma) begin
        nx.x = st[i].x - (st[i].y >>> i);
        nx.y = st[i].y + (st[i].x >>> i);
        nx.z = st[i].z - ATAN;
      end else begin
        nx.x = st[i].x + (st[i].y >>> i);
        nx.y = st[i].y - (st[i].x >>> i);
        nx.z = st[i].z + ATAN;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else if (adv) begin
        sv[i+1] <= sv[i];
      end
      if (adv) st[i+1] <= nx;
    end
  end

  assign out_d = st[CORDIC_STEPS];
  assign out_v = sv[CORDIC_STEPS];

endmodule
`default_nettype wire

>>> rtl/vapc_divider.sv
// Restoring divider pipeline, one quotient bit per stage.
`default_nettype none
module vapc_divider import vapc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic in_v,
  input  wire div_t in_d,
  output logic      out_v,
  output div_t      out_d
);

  div_t st [DIV_BITS+1];
  logic sv [DIV_BITS+1];

  assign st[0] = in_d;
  assign sv[0] = in_v;

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_bit
    localparam int B = DIV_BITS - 1 - j;
    div_t             nx;
    logic [REM_W-1:0] sh;
    always_comb begin
      nx = st[j];
      sh = REM_W'(st[j].d2) << B;
      if (st[j].rem >= sh) begin
        nx.rem  = st[j].rem - sh;
        nx.q[B] = 1'b1;
      end else begin
        nx.q[B] = 1'b0;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (adv) begin
        sv[j+1] <= sv[j];
      end
      if (adv) st[j+1] <= nx;
    end
  end

  assign out_d = st[DIV_BITS];
  assign out_v = sv[DIV_BITS];

endmodule
`default_nettype wire
